// ===== rtl/core/hftw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder package
// Shared widths, command codes, the node entry layout and the struct that
// carries symbol requests from the walker to the output stage.
// ----------------------------------------------------------------------------
package hftw_pkg;

  // Default size of the node table.
  localparam int unsigned NodeCountDef = 512;

  // Field widths.
  localparam int unsigned IdxW = 9;
  localparam int unsigned SymW = 8;
  localparam int unsigned CmdW = 2;
  localparam int unsigned InDataW = 48;

  // Command codes carried on the input tuser.
  localparam logic [CmdW-1:0] CMD_WRITE   = 2'd0;
  localparam logic [CmdW-1:0] CMD_DECODE  = 2'd1;
  localparam logic [CmdW-1:0] CMD_RESTART = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ROOT = 1'b0;

  // One node table entry.
  typedef struct packed {
    logic            leaf;
    logic [SymW-1:0] sym;
    logic [IdxW-1:0] left;
    logic [IdxW-1:0] right;
  } node_t;

  localparam int unsigned NodeW = $bits(node_t);

  // Request from the walker to the output stage.
  typedef struct packed {
    logic            emit;
    logic [SymW-1:0] sym;
    logic            flush;
  } emit_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/hftw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module hftw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array with a registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/hftw_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman decoder output stage
// Holds back the latest symbol of a byte so that the final one can be marked,
// and drives the registered output stream.
// ----------------------------------------------------------------------------
module hftw_emit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire hftw_pkg::emit_req_t            req_i,
  output logic                                ready_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic      [hftw_pkg::SymW-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);

  logic                      pend_valid_q, pend_valid_d;
  logic [hftw_pkg::SymW-1:0] pend_sym_q, pend_sym_d;
  logic                      out_valid_q, out_valid_d;
  logic [hftw_pkg::SymW-1:0] out_sym_q, out_sym_d;
  logic                      out_last_q, out_last_d;
  logic                      out_free;
  logic                      push;

  // A new symbol or a flush can be taken once the held symbol has room.
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign ready_o  = !pend_valid_q || out_free;
  assign push     = ready_o && pend_valid_q && (req_i.emit || req_i.flush);

  // Next values of the held symbol and the output register.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;
    if (push) begin
      out_valid_d = 1'b1;
      out_sym_d   = pend_sym_q;
      out_last_d  = req_i.flush;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (ready_o && req_i.emit) begin
      pend_valid_d = 1'b1;
      pend_sym_d   = req_i.sym;
    end else if (ready_o && req_i.flush) begin
      pend_valid_d = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sym_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/hftw_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman decoder tree walker
// Shifts the code byte out bit by bit and follows the node table from the
// kept walk position, one node read per step, taking no input until done.
// ----------------------------------------------------------------------------
module hftw_walk #(
  parameter int unsigned NODE_COUNT = hftw_pkg::NodeCountDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input item
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic      [hftw_pkg::CmdW-1:0]   cmd_i,
  input  wire logic      [hftw_pkg::IdxW-1:0]   node_index_i,
  input  wire logic      [hftw_pkg::SymW-1:0]   code_byte_i,
  // Register
  input  wire logic      [hftw_pkg::IdxW-1:0]   root_i,
  // Node memory
  output logic                                  mem_we_o,
  output logic                                  mem_re_o,
  output logic           [$clog2(NODE_COUNT)-1:0] mem_addr_o,
  input  wire logic      [hftw_pkg::NodeW-1:0]  mem_rdata_i,
  // Output stage
  output hftw_pkg::emit_req_t                   req_o,
  input  wire logic                             req_ready_i
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_HERE  = 2'd1;
  localparam logic [1:0] S_NEXT  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [hftw_pkg::IdxW-1:0] walk_q, walk_d;
  logic [hftw_pkg::SymW-1:0] byte_q, byte_d;
  logic [3:0]                bits_q, bits_d;
  logic                      oor_q;
  logic                      rd_en;
  logic [hftw_pkg::IdxW-1:0] rd_idx;
  logic                      wr_en;
  logic                      rd_in_range;
  logic                      wr_in_range;
  logic [31:0]               rd_wide;
  logic [31:0]               wr_wide;
  hftw_pkg::node_t           entry;
  logic [hftw_pkg::IdxW-1:0] child;

  // Entries beyond the table read as an inner node with both children zero.
  assign entry  = oor_q ? '0 : hftw_pkg::node_t'(mem_rdata_i);
  assign child  = byte_q[hftw_pkg::SymW-1] ? entry.right : entry.left;

  // Walk sequencer.
  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    byte_d     = byte_q;
    bits_d     = bits_q;
    rd_en      = 1'b0;
    rd_idx     = walk_q;
    wr_en      = 1'b0;
    in_ready_o = 1'b0;
    req_o      = '0;
    case (state_q)
      S_IDLE: begin
        // The walker is always ready here, so a valid item is a transfer.
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_i)
            hftw_pkg::CMD_WRITE: begin
              wr_en = wr_in_range;
            end
            hftw_pkg::CMD_DECODE: begin
              byte_d  = code_byte_i;
              bits_d  = 4'd8;
              rd_en   = 1'b1;
              rd_idx  = walk_q;
              state_d = S_HERE;
            end
            hftw_pkg::CMD_RESTART: begin
              walk_d = root_i;
            end
            default: begin
            end
          endcase
        end
      end
      S_HERE, S_NEXT: begin
        if (entry.leaf) begin
          // A leaf emits its symbol and sends the walk back to the root.
          req_o.emit = 1'b1;
          req_o.sym  = entry.sym;
          if (req_ready_i) begin
            walk_d = root_i;
            if (state_q == S_HERE) begin
              bits_d = bits_q - 4'd1;
              byte_d = {byte_q[hftw_pkg::SymW-2:0], 1'b0};
            end
            if ((state_q == S_HERE && bits_q == 4'd1) ||
                (state_q == S_NEXT && bits_q == 4'd0)) begin
              state_d = S_FLUSH;
            end else begin
              rd_en   = 1'b1;
              rd_idx  = root_i;
              state_d = S_HERE;
            end
          end
        end else if (bits_q == 4'd0) begin
          state_d = S_FLUSH;
        end else begin
          // An inner node: step to the child chosen by the next code bit.
          walk_d  = child;
          bits_d  = bits_q - 4'd1;
          byte_d  = {byte_q[hftw_pkg::SymW-2:0], 1'b0};
          rd_en   = 1'b1;
          rd_idx  = child;
          state_d = S_NEXT;
        end
      end
      S_FLUSH: begin
        req_o.flush = 1'b1;
        if (req_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Table range checks and memory address.
  assign rd_wide     = 32'(rd_idx);
  assign wr_wide     = 32'(node_index_i);
  assign rd_in_range = rd_wide < NODE_COUNT;
  assign wr_in_range = wr_wide < NODE_COUNT;
  assign mem_we_o    = wr_en;
  assign mem_re_o    = rd_en;
  assign mem_addr_o  = wr_en ? wr_wide[AW-1:0] : rd_wide[AW-1:0];

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q  <= '0;
      bits_q  <= '0;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      walk_q  <= walk_d;
      bits_q  <= bits_d;
      if (rd_en) begin
        oor_q <= !rd_in_range;
      end
    end
  end

  // Code bit shift register.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule
`default_nettype wire

// ===== rtl/core/huffman_tree_walk_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman tree-walk decoder
// Decodes compressed bytes by walking a node table loaded beforehand.
// ----------------------------------------------------------------------------
// Load the tree with node writes (tuser 0), set root_index, then send a
// restart (tuser 2) and the code bytes (tuser 1). Node writes, restarts and
// other commands are done in the idle state without a walk. A code byte
// first fetches the current node and then takes one node read per code bit,
// plus one more read for every leaf reached through a child, when the walk
// re-fetches the root; a closing step marks the last symbol. The reads share
// the single read port of the node memory, and the walk waits while the
// output stream is stalled. Each leaf reached gives one symbol on the
// output stream, up to eight per byte, and tlast marks the final symbol of
// the byte; a byte that reaches no leaf gives nothing. The walk position
// carries over from byte to byte. The node table is not cleared at reset;
// walking into an entry that was never written gives undefined symbols.
// ----------------------------------------------------------------------------
module huffman_tree_walk_decoder_unit #(
  parameter int unsigned NODE_COUNT = hftw_pkg::NodeCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: node_index[8:0], node_is_leaf[9], node_symbol[17:10],
  //        left_child[26:18], right_child[35:27], code_byte[43:36], zero
  input  wire logic [hftw_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: cmd[1:0]
  input  wire logic [hftw_pkg::CmdW-1:0]     s_axis_tuser_i,
  // Output stream
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // tdata: symbol[7:0]
  output logic      [hftw_pkg::SymW-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  localparam int unsigned AW = $clog2(NODE_COUNT);

  logic [hftw_pkg::IdxW-1:0]  root_q;
  hftw_pkg::node_t            node_in;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_addr;
  logic [hftw_pkg::NodeW-1:0] mem_rdata;
  hftw_pkg::emit_req_t        req;
  logic                       req_ready;

  // Register file: one root index register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == hftw_pkg::REG_ROOT) ? 32'(root_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == hftw_pkg::REG_ROOT) begin
      root_q <= pwdata[hftw_pkg::IdxW-1:0];
    end
  end

  // Unpack the node fields of an input transfer.
  assign node_in.leaf  = s_axis_tdata_i[9];
  assign node_in.sym   = s_axis_tdata_i[17:10];
  assign node_in.left  = s_axis_tdata_i[26:18];
  assign node_in.right = s_axis_tdata_i[35:27];

  hftw_walk #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .cmd_i        (s_axis_tuser_i),
    .node_index_i (s_axis_tdata_i[8:0]),
    .code_byte_i  (s_axis_tdata_i[43:36]),
    .root_i       (root_q),
    .mem_we_o     (mem_we),
    .mem_re_o     (mem_re),
    .mem_addr_o   (mem_addr),
    .mem_rdata_i  (mem_rdata),
    .req_o        (req),
    .req_ready_i  (req_ready)
  );

  hftw_ram #(
    .WIDTH (hftw_pkg::NodeW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (node_in),
    .rdata_o (mem_rdata)
  );

  hftw_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req),
    .ready_o         (req_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

// ===== rtl/core/hftw_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman decoder port checker
// Watches the stream ports of the decoder and flags sequencing errors.
// ----------------------------------------------------------------------------
module hftw_chk (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      s_axis_tvalid_i,
  input wire logic                      s_axis_tready_o,
  input wire logic [hftw_pkg::CmdW-1:0] s_axis_tuser_i,
  input wire logic                      m_axis_tvalid_o,
  input wire logic                      m_axis_tready_i,
  input wire logic [hftw_pkg::SymW-1:0] m_axis_tdata_o,
  input wire logic                      m_axis_tlast_o
);

  // A decode transfer occupies the walker, so input is refused next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == hftw_pkg::CMD_DECODE
    |=> !s_axis_tready_o)
    else $error("input accepted directly after a decode transfer");

  // Any other command leaves the input ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i != hftw_pkg::CMD_DECODE
    |=> s_axis_tready_o)
    else $error("non-decode transfer stalled the input");

  // Symbols only appear as the result of a byte under decode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("output symbol appeared while the walker was idle");

  // A stalled output transfer keeps its symbol and marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i
    |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output transfer changed");

endmodule

bind huffman_tree_walk_decoder_unit hftw_chk u_hftw_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

// ===== tb/sv/tb_huffman_tree_walk_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the Huffman tree-walk decoder
// Loads node tables over the input stream, moves the root register over the
// configuration port and decodes code bytes. A tree walk kept in the
// testbench predicts every symbol, and each symbol on the output stream is
// compared with it in order.
// ----------------------------------------------------------------------------
module tb_huffman_tree_walk_decoder_unit;
  import hftw_pkg::*;

  localparam int unsigned TableSize = NodeCountDef;
  // Command code that the decoder ignores.
  localparam logic [CmdW-1:0] CMD_NONE = 2'd3;
  localparam logic [2:0] AddrRoot  = {REG_ROOT, 2'b00};
  localparam logic [2:0] AddrSpare = {~REG_ROOT, 2'b00};
  localparam int SettleCycles = 40;
  localparam int CycleLimit   = 400000;
  localparam int RandomItems  = 350;
  localparam int MaxReports   = 40;

  // Predicts the decoded symbols and checks them as they leave the block.
  class symbol_scoreboard;
    typedef struct {
      logic [SymW-1:0] sym;
      logic            last;
    } symbol_t;

    node_t           node_mem [TableSize];
    logic [IdxW-1:0] walk_pos;
    logic [IdxW-1:0] root_idx;
    symbol_t         expected_q [$];
    int              errors;

    function new();
      foreach (node_mem[i]) node_mem[i] = '0;
      walk_pos = '0;
      root_idx = '0;
      errors   = 0;
    endfunction

    function void flag(string msg);
      if (errors < MaxReports) $error("%s", msg);
      errors++;
    endfunction

    // Only the root register exists; other addresses are ignored.
    function void write_register(logic [2:0] addr, logic [31:0] value);
      if (addr == AddrRoot) root_idx = value[IdxW-1:0];
    endfunction

    // Notes one accepted input transfer and queues the symbols it will cause.
    function void note_input(logic [CmdW-1:0] cmd, logic [InDataW-1:0] data);
      node_t           here;
      symbol_t         found [$];
      symbol_t         s;
      logic [SymW-1:0] code;
      case (cmd)
        CMD_WRITE: begin
          here.leaf  = data[9];
          here.sym   = data[17:10];
          here.left  = data[26:18];
          here.right = data[35:27];
          node_mem[data[8:0]] = here;
        end
        CMD_RESTART: walk_pos = root_idx;
        CMD_DECODE: begin
          code = data[43:36];
          for (int b = SymW - 1; b >= 0; b--) begin
            here = node_mem[walk_pos];
            // A leaf sitting at the walk position emits without a child step.
            if (!here.leaf) begin
              walk_pos = code[b] ? here.right : here.left;
              here = node_mem[walk_pos];
            end
            if (here.leaf) begin
              s.sym  = here.sym;
              s.last = 1'b0;
              found.push_back(s);
              walk_pos = root_idx;
            end
          end
          if (found.size() > 0) found[found.size()-1].last = 1'b1;
          foreach (found[i]) expected_q.push_back(found[i]);
        end
        default: ;
      endcase
    endfunction

    // Compares one output transfer with the oldest predicted symbol.
    function void check_symbol(logic [SymW-1:0] sym, logic last);
      symbol_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("symbol: expected none, got 0x%02h (last %0b)", sym, last));
        return;
      end
      want = expected_q.pop_front();
      if (sym !== want.sym)
        flag($sformatf("symbol: expected 0x%02h, got 0x%02h", want.sym, sym));
      if (last !== want.last)
        flag($sformatf("last: expected %0b, got %0b", want.last, last));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [CmdW-1:0]     s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [SymW-1:0]     m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  symbol_scoreboard    sb = new();
  bit [TableSize-1:0]  node_written = '0;
  int                  src_idle = 18;
  int                  sink_idle = 58;
  int                  items_sent = 0;

  huffman_tree_walk_decoder_unit uut (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Output side: check each transfer and stall at random.
  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_symbol(m_axis_tdata_o, m_axis_tlast_o);
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle);
    end
  end

  function automatic logic [IdxW-1:0] rand_idx();
    return IdxW'($urandom_range(TableSize - 1));
  endfunction

  function automatic logic [SymW-1:0] rand_byte();
    return SymW'($urandom_range(255));
  endfunction

  // Any table entry that has been written, so that the walk never leaves them.
  function automatic logic [IdxW-1:0] pick_written();
    logic [IdxW-1:0] idx;
    do idx = rand_idx(); while (!node_written[idx]);
    return idx;
  endfunction

  function automatic logic [InDataW-1:0] pack_item(logic [IdxW-1:0] idx, logic leaf,
                                                   logic [SymW-1:0] sym,
                                                   logic [IdxW-1:0] lc, logic [IdxW-1:0] rc,
                                                   logic [SymW-1:0] code);
    return {{(InDataW - 44){1'b0}}, code, rc, lc, sym, leaf, idx};
  endfunction

  // Offers one input transfer, with random gaps ahead of it.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [InDataW-1:0] data);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= data;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(cmd, data);
    items_sent++;
  endtask

  task automatic write_node(input logic [IdxW-1:0] idx, input logic leaf,
                            input logic [SymW-1:0] sym,
                            input logic [IdxW-1:0] lc, input logic [IdxW-1:0] rc);
    send_item(CMD_WRITE, pack_item(idx, leaf, sym, lc, rc, rand_byte()));
    node_written[idx] = 1'b1;
  endtask

  // Decode, restart or ignored command; the node fields carry noise.
  task automatic send_op(input logic [CmdW-1:0] cmd, input logic [SymW-1:0] code);
    send_item(cmd, pack_item(rand_idx(), 1'($urandom_range(1)), rand_byte(),
                             rand_idx(), rand_idx(), code));
  endtask

  // Register write: setup phase, then access phase until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_register(addr, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Holds the input back until every predicted symbol has arrived.
  task automatic drain_symbols();
    s_axis_tvalid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Builds a random full binary tree on distinct table entries and loads it.
  task automatic load_tree(input int leaves, output logic [IdxW-1:0] top);
    logic [IdxW-1:0]    ids [$];
    int                 lc [$];
    int                 rc [$];
    int                 open [$];
    bit [TableSize-1:0] taken;
    logic [IdxW-1:0]    idx;
    int                 k;
    int                 slot;
    int                 r;
    taken = '0;
    for (int n = 0; n < 2 * leaves - 1; n++) begin
      do begin
        r = int'($urandom_range(9));
        idx = (r == 0) ? 9'd0 : (r == 1) ? 9'd511 : rand_idx();
      end while (taken[idx]);
      taken[idx] = 1'b1;
      ids.push_back(idx);
      lc.push_back(-1);
      rc.push_back(-1);
    end
    // Split a random leaf into an inner node until there are enough leaves.
    open.push_back(0);
    slot = 1;
    while (open.size() < leaves) begin
      k = int'($urandom_range(open.size() - 1));
      lc[open[k]] = slot;
      rc[open[k]] = slot + 1;
      open.delete(k);
      open.push_back(slot);
      open.push_back(slot + 1);
      slot += 2;
    end
    foreach (ids[n]) begin
      if (lc[n] < 0)
        write_node(ids[n], 1'b1, rand_byte(), rand_idx(), rand_idx());
      else
        write_node(ids[n], 1'b0, rand_byte(), ids[lc[n]], ids[rc[n]]);
    end
    top = ids[0];
  endtask

  // Stimulus.
  initial begin
    logic [IdxW-1:0] top;
    logic [IdxW-1:0] idx;
    logic [31:0]     value;
    int              base;
    int              r;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_WRITE;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= AddrRoot;
    pwdata          <= '0;
    rst_ni          <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Small tree at the reset root, with entries at both ends of the table.
    write_node(9'd0, 1'b0, 8'h3C, 9'd511, 9'd1);
    write_node(9'd511, 1'b1, 8'h00, 9'd0, 9'd511);
    write_node(9'd1, 1'b0, 8'hC3, 9'd2, 9'd3);
    write_node(9'd2, 1'b1, 8'hFF, 9'd511, 9'd0);
    write_node(9'd3, 1'b1, 8'hA5, 9'd0, 9'd0);
    send_op(CMD_DECODE, 8'h00);
    send_op(CMD_DECODE, 8'hFF);
    send_op(CMD_DECODE, 8'h5A);
    // The walk stops half way down and resumes in the next byte.
    send_op(CMD_DECODE, 8'h01);
    send_op(CMD_DECODE, 8'h80);
    send_op(CMD_DECODE, 8'h01);
    send_op(CMD_RESTART, 8'h00);
    send_op(CMD_DECODE, 8'h01);
    // The ignored command must leave the half walk where it is.
    send_op(CMD_NONE, 8'hFF);
    send_op(CMD_DECODE, 8'hC0);
    send_op(CMD_DECODE, 8'h01);

    // A leaf as root: the walk only moves there when it reaches a leaf.
    drain_symbols();
    write_reg(AddrRoot, 32'h0000_01FF);
    send_op(CMD_DECODE, 8'h80);
    send_op(CMD_RESTART, 8'h55);
    send_op(CMD_DECODE, 8'h3C);

    // An inner node that points at itself gives bytes with no symbol.
    drain_symbols();
    write_reg(AddrSpare, 32'hFFFF_FFFF);
    write_node(9'd6, 1'b0, 8'h81, 9'd6, 9'd6);
    drain_symbols();
    write_reg(AddrRoot, 32'd6);
    send_op(CMD_RESTART, 8'hAA);
    send_op(CMD_DECODE, 8'hFF);
    send_op(CMD_DECODE, 8'h12);
    drain_symbols();
    write_reg(AddrRoot, 32'hFFFF_FE00);
    send_op(CMD_RESTART, 8'h0F);
    send_op(CMD_DECODE, 8'hE7);

    // Random trees, each followed by a burst of mostly code bytes.
    base = items_sent;
    while (items_sent - base < RandomItems) begin
      if (items_sent - base >= 2 * RandomItems / 3) begin
        src_idle  = 0;
        sink_idle = 0;
      end else if (items_sent - base >= RandomItems / 3) begin
        src_idle  = 58;
        sink_idle = 18;
      end
      drain_symbols();
      load_tree(int'($urandom_range(1, 10)), top);
      drain_symbols();
      if ($urandom_range(7) == 0) write_reg(AddrSpare, $urandom());
      value = $urandom();
      value[IdxW-1:0] = top;
      write_reg(AddrRoot, value);
      // Without a restart the walk finishes in the old tree first.
      if ($urandom_range(3) != 0) send_op(CMD_RESTART, rand_byte());
      repeat ($urandom_range(6, 18)) begin
        r = int'($urandom_range(99));
        if (r < 80) begin
          send_op(CMD_DECODE, rand_byte());
        end else if (r < 88) begin
          // Rewrite some entry, keeping every reachable child written.
          idx = rand_idx();
          if ($urandom_range(1) == 1) begin
            write_node(idx, 1'b1, rand_byte(), rand_idx(), rand_idx());
          end else begin
            node_written[idx] = 1'b1;
            write_node(idx, 1'b0, rand_byte(), pick_written(), pick_written());
          end
        end else if (r < 94) begin
          send_op(CMD_RESTART, rand_byte());
        end else begin
          send_op(CMD_NONE, rand_byte());
        end
      end
    end

    drain_symbols();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hftw_pkg.sv
rtl/core/hftw_ram.sv
rtl/core/hftw_emit.sv
rtl/core/hftw_walk.sv
rtl/core/huffman_tree_walk_decoder_unit.sv
rtl/core/hftw_chk.sv
tb/sv/tb_huffman_tree_walk_decoder_unit.sv
